### src/tcw_pkg.sv
// Shared types and constants for the text console character writer.
package tcw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int POS_W  = 11;
  localparam int LIN_W  = 12;
  localparam int BYTE_W = 8;
  localparam int CELL_W = 16;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [BYTE_W-1:0] CH_BS    = 8'h08;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

  localparam logic [BYTE_W-1:0] RST_TEXT_ATTR  = 8'h0A;
  localparam logic [BYTE_W-1:0] RST_BLANK_ATTR = 8'h07;

  localparam logic CFG_TEXT_ATTR  = 1'b0;
  localparam logic CFG_BLANK_ATTR = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_RD,
    ST_RD_DAT,
    ST_DONE
  } tcw_state_t;

  typedef enum logic [1:0] {
    PK_BS,
    PK_NL,
    PK_CHR
  } put_kind_t;

endpackage

### src/tcw_lin_unit.sv
// Shared multiply-add unit: row times COLS plus an offset.
module tcw_lin_unit #(
  parameter int COLS = 80
) (
  input  logic [tcw_pkg::ROW_W-1:0] mul_a,
  input  logic [tcw_pkg::LIN_W-1:0] add_b,
  output logic [tcw_pkg::LIN_W-1:0] lin
);
  import tcw_pkg::*;

  logic [LIN_W-1:0] prod;

  assign prod = LIN_W'(mul_a) * LIN_W'(COLS);
  assign lin  = prod + add_b;

endmodule

### src/tcw_cell_ram.sv
// Cell store: one write port and one registered read port.
module tcw_cell_ram #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### src/tcw_ctrl.sv
// Sequencer: cursor, store sweeps, scroll copy and the result register.
module tcw_ctrl #(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int AW   = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [tcw_pkg::BYTE_W-1:0]  in_char,
  input  logic [tcw_pkg::ROW_W-1:0]   in_row,
  input  logic [tcw_pkg::COL_W-1:0]   in_col,
  input  logic [tcw_pkg::BYTE_W-1:0]  text_attr,
  input  logic [tcw_pkg::BYTE_W-1:0]  blank_attr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [tcw_pkg::COL_W-1:0]   out_col,
  output logic [tcw_pkg::ROW_W-1:0]   out_row,
  output logic [tcw_pkg::POS_W-1:0]   out_pos,
  output logic [tcw_pkg::BYTE_W-1:0]  out_char,
  output logic [tcw_pkg::BYTE_W-1:0]  out_attr,
  output logic                        out_scrolled,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [tcw_pkg::CELL_W-1:0]  ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int LAST  = (ROWS - 1) * COLS;

  tcw_state_t        state_r, state_nxt;
  put_kind_t         kind_r, kind_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [AW-1:0]     ptr_r, ptr_nxt;
  logic [BYTE_W-1:0] wchar_r, wchar_nxt;
  logic [BYTE_W-1:0] fill_attr_r, fill_attr_nxt;
  logic              rst_fill_r, rst_fill_nxt;
  logic [ROW_W-1:0]  rr_r, rr_nxt;
  logic [COL_W-1:0]  rc_r, rc_nxt;
  logic              in_rng_r, in_rng_nxt;
  logic [BYTE_W-1:0] res_char_r, res_char_nxt;
  logic [BYTE_W-1:0] res_attr_r, res_attr_nxt;
  logic              res_scr_r, res_scr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_load;

  logic [ROW_W-1:0]  lin_a;
  logic [LIN_W-1:0]  lin_b;
  logic [LIN_W-1:0]  lin;
  logic [COL_W-1:0]  col_p1;
  logic [ROW_W-1:0]  row_p1;

  tcw_lin_unit #(.COLS(COLS)) u_lin (
    .mul_a (lin_a),
    .add_b (lin_b),
    .lin   (lin)
  );

  assign col_p1   = col_r + COL_W'(1);
  assign row_p1   = row_r + ROW_W'(1);
  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    case (state_r)
      ST_RD: begin
        lin_a = rr_r;
        lin_b = LIN_W'(rc_r);
      end
      ST_SCR_RD: begin
        lin_a = ROW_W'(1);
        lin_b = LIN_W'(ptr_r);
      end
      default: begin
        lin_a = row_r;
        lin_b = LIN_W'(col_r);
      end
    endcase
  end

  assign ram_raddr = lin[AW-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_r;
    ram_wdata = {fill_attr_r, CH_SPACE};
    case (state_r)
      ST_PUT: begin
        ram_we    = (kind_r != PK_NL);
        ram_waddr = lin[AW-1:0];
        ram_wdata = {text_attr, wchar_r};
      end
      ST_SCR_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      ST_FILL: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    ptr_nxt       = ptr_r;
    wchar_nxt     = wchar_r;
    fill_attr_nxt = fill_attr_r;
    rst_fill_nxt  = rst_fill_r;
    rr_nxt        = rr_r;
    rc_nxt        = rc_r;
    in_rng_nxt    = in_rng_r;
    res_char_nxt  = res_char_r;
    res_attr_nxt  = res_attr_r;
    res_scr_nxt   = res_scr_r;
    out_load      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          res_char_nxt = '0;
          res_attr_nxt = '0;
          res_scr_nxt  = 1'b0;
          case (in_opcode)
            OP_PUT: begin
              state_nxt = ST_PUT;
              if (in_char == CH_BS) begin
                kind_nxt  = PK_BS;
                wchar_nxt = CH_SPACE;
                if (col_r != '0) begin
                  col_nxt = col_r - COL_W'(1);
                end else if (row_r != '0) begin
                  row_nxt = row_r - ROW_W'(1);
                  col_nxt = COL_W'(COLS - 1);
                end
              end else if (in_char == CH_NL) begin
                kind_nxt = PK_NL;
              end else begin
                kind_nxt  = PK_CHR;
                wchar_nxt = in_char;
              end
            end
            OP_CLEAR: begin
              state_nxt     = ST_FILL;
              col_nxt       = '0;
              row_nxt       = '0;
              ptr_nxt       = '0;
              fill_attr_nxt = blank_attr;
            end
            OP_READ: begin
              state_nxt  = ST_RD;
              rr_nxt     = in_row;
              rc_nxt     = in_col;
              in_rng_nxt = (in_row < ROW_W'(ROWS)) && (in_col < COL_W'(COLS));
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_PUT: begin
        state_nxt = ST_DONE;
        if (kind_r == PK_NL) begin
          col_nxt = '0;
          row_nxt = row_p1;
        end else if (kind_r == PK_CHR) begin
          if (col_p1 >= COL_W'(COLS)) begin
            col_nxt = '0;
            row_nxt = row_p1;
          end else begin
            col_nxt = col_p1;
          end
        end
        if ((kind_r != PK_BS) && (row_nxt >= ROW_W'(ROWS))) begin
          row_nxt     = ROW_W'(ROWS - 1);
          res_scr_nxt = 1'b1;
          ptr_nxt     = '0;
          state_nxt   = ST_SCR_RD;
        end
      end
      ST_SCR_RD: begin
        state_nxt = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == AW'(LAST - 1)) begin
          fill_attr_nxt = blank_attr;
          state_nxt     = ST_FILL;
        end else begin
          state_nxt = ST_SCR_RD;
        end
      end
      ST_FILL: begin
        ptr_nxt = ptr_r + AW'(1);
        if (ptr_r == AW'(CELLS - 1)) begin
          rst_fill_nxt = 1'b0;
          state_nxt    = rst_fill_r ? ST_IDLE : ST_DONE;
        end
      end
      ST_RD: begin
        state_nxt = ST_RD_DAT;
      end
      ST_RD_DAT: begin
        state_nxt = ST_DONE;
        if (in_rng_r) begin
          res_char_nxt = ram_rdata[BYTE_W-1:0];
          res_attr_nxt = ram_rdata[CELL_W-1:BYTE_W];
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      col_r       <= '0;
      row_r       <= '0;
      ptr_r       <= '0;
      fill_attr_r <= RST_BLANK_ATTR;
      rst_fill_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      ptr_r       <= ptr_nxt;
      fill_attr_r <= fill_attr_nxt;
      rst_fill_r  <= rst_fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    wchar_r    <= wchar_nxt;
    rr_r       <= rr_nxt;
    rc_r       <= rc_nxt;
    in_rng_r   <= in_rng_nxt;
    res_char_r <= res_char_nxt;
    res_attr_r <= res_attr_nxt;
    res_scr_r  <= res_scr_nxt;
    if (out_load) begin
      out_col      <= col_r;
      out_row      <= row_r;
      out_pos      <= lin[POS_W-1:0];
      out_char     <= res_char_r;
      out_attr     <= res_attr_r;
      out_scrolled <= res_scr_r;
    end
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result register loaded outside the done state");

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (col_r < COL_W'(COLS)) && (row_r < ROW_W'(ROWS)))
    else $error("cursor outside the screen");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (LIN_W'(ram_waddr) < LIN_W'(CELLS)))
    else $error("store write beyond the last cell");

  a_reset_sweep_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    rst_fill_r |-> !out_valid_r && (state_r == ST_FILL))
    else $error("activity during the reset clearing pass");

endmodule

### src/text_console_char_writer.sv
// Top level of the text console character writer.
//
//  channel | signals                          | request accepted when
//  --------+----------------------------------+------------------------------
//  input   | in_tvalid, in_tready, in_tdata   | in_tvalid && in_tready
//  result  | out_tvalid, out_tready, out_tdata| out_tvalid && out_tready
//  config  | cfg_we, cfg_addr, cfg_wdata      | cfg_we
//
// A scroll copies the store through the single read port.
// A clear sweeps the store one cell a cycle.
// After reset the store is cleared one cell a cycle, with in_tready low.
// The result register lets the next request enter while a result waits.
module text_console_char_writer #(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode[1:0], char_code[9:2], read_row[14:10], read_col[21:15], zeros above
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cursor_col[6:0], cursor_row[11:7], cursor_position[22:12],
  // cell_char[30:23], cell_attr[38:31], scrolled[39]
  output logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);

  logic [BYTE_W-1:0] text_attr_r;
  logic [BYTE_W-1:0] blank_attr_r;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic [COL_W-1:0]  out_col;
  logic [ROW_W-1:0]  out_row;
  logic [POS_W-1:0]  out_pos;
  logic [BYTE_W-1:0] out_char;
  logic [BYTE_W-1:0] out_attr;
  logic              out_scrolled;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r  <= RST_TEXT_ATTR;
      blank_attr_r <= RST_BLANK_ATTR;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_TEXT_ATTR:  text_attr_r  <= cfg_wdata;
        CFG_BLANK_ATTR: blank_attr_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  tcw_cell_ram #(.DEPTH(CELLS), .AW(AW)) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  tcw_ctrl #(.COLS(COLS), .ROWS(ROWS), .AW(AW)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_opcode    (in_tdata[1:0]),
    .in_char      (in_tdata[9:2]),
    .in_row       (in_tdata[14:10]),
    .in_col       (in_tdata[21:15]),
    .text_attr    (text_attr_r),
    .blank_attr   (blank_attr_r),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_col      (out_col),
    .out_row      (out_row),
    .out_pos      (out_pos),
    .out_char     (out_char),
    .out_attr     (out_attr),
    .out_scrolled (out_scrolled),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  assign out_tdata = {out_scrolled, out_attr, out_char, out_pos, out_row, out_col};

endmodule

### tb/sv/text_console_char_writer_test.sv
// Self-checking testbench for the text console character writer: directed cases, then random streams.
module text_console_char_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam int CELLS = ROWS * COLS;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int MAX_PRINTED = 40;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic [COL_W-1:0]  read_col;
    logic [ROW_W-1:0]  read_row;
    logic [BYTE_W-1:0] char_code;
    logic [1:0]        opcode;
  } console_request_t;

  typedef struct packed {
    logic              scrolled;
    logic [BYTE_W-1:0] cell_attr;
    logic [BYTE_W-1:0] cell_char;
    logic [POS_W-1:0]  cursor_position;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_col;
  } console_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;
  logic        cfg_we;
  logic        cfg_addr;
  logic [7:0]  cfg_wdata;

  logic [CELL_W-1:0] screen_cells [CELLS];
  int unsigned       model_col;
  int unsigned       model_row;
  logic [BYTE_W-1:0] model_text_attr;
  logic [BYTE_W-1:0] model_blank_attr;
  console_result_t   cursor_results [$];
  int unsigned       error_count = 0;
  bit                source_steady = 1'b0;
  bit                sink_steady = 1'b0;
  bit                hold_off_pending = 1'b0;

  text_console_char_writer #(.COLS(COLS), .ROWS(ROWS)) dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic void blank_screen();
    for (int i = 0; i < CELLS; i++) screen_cells[i] = {model_blank_attr, CH_SPACE};
  endfunction

  function automatic bit advance_put(logic [BYTE_W-1:0] ch);
    if (ch == CH_BS) begin
      if (model_col > 0) begin
        model_col--;
      end else if (model_row > 0) begin
        model_row--;
        model_col = COLS - 1;
      end
      screen_cells[model_row * COLS + model_col] = {model_text_attr, CH_SPACE};
      return 1'b0;
    end
    if (ch == CH_NL) begin
      model_col = 0;
      model_row++;
    end else begin
      screen_cells[model_row * COLS + model_col] = {model_text_attr, ch};
      model_col++;
    end
    if (model_col >= COLS) begin
      model_col = 0;
      model_row++;
    end
    if (model_row >= ROWS) begin
      for (int i = 0; i < (ROWS - 1) * COLS; i++) screen_cells[i] = screen_cells[i + COLS];
      for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
        screen_cells[i] = {model_blank_attr, CH_SPACE};
      model_row = ROWS - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic console_result_t predict_console_step(console_request_t req);
    console_result_t res;
    res = '0;
    case (req.opcode)
      OP_PUT: res.scrolled = advance_put(req.char_code);
      OP_CLEAR: begin
        blank_screen();
        model_col = 0;
        model_row = 0;
      end
      OP_READ: begin
        if (req.read_row < ROW_W'(ROWS) && req.read_col < COL_W'(COLS))
          {res.cell_attr, res.cell_char} = screen_cells[req.read_row * COLS + req.read_col];
      end
      default: ;
    endcase
    res.cursor_col = COL_W'(model_col);
    res.cursor_row = ROW_W'(model_row);
    res.cursor_position = POS_W'(model_row * COLS + model_col);
    return res;
  endfunction

  function automatic console_request_t make_request(logic [1:0] op, logic [BYTE_W-1:0] ch,
                                                    logic [ROW_W-1:0] row, logic [COL_W-1:0] col);
    console_request_t req;
    req.opcode = op;
    req.char_code = ch;
    req.read_row = row;
    req.read_col = col;
    return req;
  endfunction

  function automatic console_request_t random_request();
    console_request_t req;
    int roll;
    int linear;
    int back;
    req = make_request(OP_PUT, BYTE_W'($urandom_range(255)), ROW_W'($urandom_range(31)),
                       COL_W'($urandom_range(127)));
    roll = $urandom_range(999);
    if (roll < 640) begin
      req.opcode = OP_PUT;
    end else if (roll < 680) begin
      req.char_code = CH_NL;
    end else if (roll < 740) begin
      req.char_code = CH_BS;
    end else if (roll < 950) begin
      req.opcode = OP_READ;
      roll = $urandom_range(9);
      if (roll < 5) begin
        linear = model_row * COLS + model_col;
        back = $urandom_range(3 * COLS, 1);
        linear = (linear >= back) ? linear - back : $urandom_range(CELLS - 1);
        req.read_row = ROW_W'(linear / COLS);
        req.read_col = COL_W'(linear % COLS);
      end else if (roll < 9) begin
        req.read_row = ROW_W'($urandom_range(ROWS - 1));
        req.read_col = COL_W'($urandom_range(COLS - 1));
      end
    end else if (roll < 980) begin
      req.opcode = OP_UNUSED;
    end else begin
      req.opcode = OP_CLEAR;
    end
    return req;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
  endtask

  task automatic send_request(console_request_t req);
    int gap;
    in_tdata <= {2'b00, req};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    cursor_results.push_back(predict_console_step(req));
    gap = source_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_register(logic idx, logic [BYTE_W-1:0] value);
    cfg_addr <= idx;
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_TEXT_ATTR) model_text_attr = value;
    else model_blank_attr = value;
    @(posedge clk);
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (cursor_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_contents();
    send_request(make_request(OP_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'hFF, ROW_W'(ROWS - 1), COL_W'(COLS - 1)));
    send_request(make_request(OP_READ, 8'h55, ROW_W'(ROWS / 2), COL_W'(COLS / 2)));
  endtask

  task automatic test_directed_cases();
    write_register(CFG_TEXT_ATTR, 8'hFF);
    write_register(CFG_BLANK_ATTR, 8'h00);
    send_request(make_request(OP_CLEAR, 8'hFF, 5'd31, 7'd127));
    send_request(make_request(OP_PUT, CH_BS, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_request(OP_PUT, 8'hFF, 5'd31, 7'd127));
    send_request(make_request(OP_PUT, 8'h00, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'h00, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'h00, 5'd0, 7'd1));
    send_request(make_request(OP_PUT, CH_NL, 5'd0, 7'd0));
    send_request(make_request(OP_PUT, CH_BS, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'h00, 5'd0, COL_W'(COLS - 1)));
    send_request(make_request(OP_PUT, 8'h7E, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'h00, 5'd0, COL_W'(COLS - 1)));
    send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLS - 1)));
    send_request(make_request(OP_READ, 8'h00, 5'd31, 7'd0));
    send_request(make_request(OP_READ, 8'h00, 5'd0, 7'd127));
    send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS), COL_W'(COLS - 1)));
    send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLS)));
    send_request(make_request(OP_UNUSED, 8'hFF, 5'd31, 7'd127));
    send_request(make_request(OP_CLEAR, 8'h00, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'hFF, 5'd0, COL_W'(COLS - 1)));
  endtask

  task automatic test_scroll_and_wrap();
    write_register(CFG_TEXT_ATTR, 8'h00);
    write_register(CFG_BLANK_ATTR, 8'hFF);
    send_request(make_request(OP_CLEAR, 8'h00, 5'd0, 7'd0));
    repeat (ROWS - 1) send_request(make_request(OP_PUT, CH_NL, 5'd0, 7'd0));
    for (int i = 0; i < 3; i++)
      send_request(make_request(OP_PUT, BYTE_W'(8'h41 + i), 5'd0, 7'd0));
    send_request(make_request(OP_PUT, CH_NL, 5'd0, 7'd0));
    for (int i = 0; i < 3; i++)
      send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS - 2), COL_W'(i)));
    send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS - 1), 7'd0));
    for (int i = 0; i < COLS; i++)
      send_request(make_request(OP_PUT, BYTE_W'($urandom_range(8'h7E, 8'h21)), 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS - 2), COL_W'(COLS - 1)));
    send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS - 1), COL_W'(COLS - 1)));
    send_request(make_request(OP_PUT, CH_BS, 5'd0, 7'd0));
    send_request(make_request(OP_READ, 8'h00, ROW_W'(ROWS - 2), COL_W'(COLS - 1)));
  endtask

  task automatic test_random_phases();
    logic [BYTE_W-1:0] text_values [4];
    logic [BYTE_W-1:0] blank_values [4];
    text_values = '{8'hFF, 8'h00, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255))};
    blank_values = '{8'h00, 8'hFF, BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255))};
    for (int phase = 0; phase < 4; phase++) begin
      wait_until_idle();
      write_register(CFG_TEXT_ATTR, text_values[phase]);
      write_register(CFG_BLANK_ATTR, blank_values[phase]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        source_steady = (phase == 1 && i < PHASE_ITEMS / 2);
        sink_steady = source_steady;
        send_request(random_request());
      end
    end
    source_steady = 1'b0;
    sink_steady = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_off_pending = 1'b1;
    source_steady = 1'b1;
    repeat (40) send_request(random_request());
    source_steady = 1'b0;
  endtask

  initial begin : result_sink
    int stall;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        stall = HOLD_OFF_CYCLES;
      end else begin
        stall = sink_steady ? 0 : pick_gap();
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    console_result_t got;
    console_result_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      got = out_tdata;
      if (cursor_results.size() == 0) begin
        report_mismatch("result with nothing pending, cursor_position",
                        int'(got.cursor_position), -1);
      end else begin
        want = cursor_results.pop_front();
        if (got.cursor_col !== want.cursor_col)
          report_mismatch("cursor_col", int'(got.cursor_col), int'(want.cursor_col));
        if (got.cursor_row !== want.cursor_row)
          report_mismatch("cursor_row", int'(got.cursor_row), int'(want.cursor_row));
        if (got.cursor_position !== want.cursor_position)
          report_mismatch("cursor_position", int'(got.cursor_position),
                          int'(want.cursor_position));
        if (got.cell_char !== want.cell_char)
          report_mismatch("cell_char", int'(got.cell_char), int'(want.cell_char));
        if (got.cell_attr !== want.cell_attr)
          report_mismatch("cell_attr", int'(got.cell_attr), int'(want.cell_attr));
        if (got.scrolled !== want.scrolled)
          report_mismatch("scrolled", int'(got.scrolled), int'(want.scrolled));
      end
    end
  end

  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_we <= 1'b0;
    cfg_addr <= 1'b0;
    cfg_wdata <= '0;
    rst_n <= 1'b0;
    model_text_attr = RST_TEXT_ATTR;
    model_blank_attr = RST_BLANK_ATTR;
    model_col = 0;
    model_row = 0;
    blank_screen();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    test_reset_contents();
    wait_until_idle();
    test_directed_cases();
    wait_until_idle();
    test_scroll_and_wrap();
    wait_until_idle();
    test_random_phases();
    wait_until_idle();
    test_backpressure();
    wait_until_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && cursor_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### text_console_char_writer.f
src/tcw_pkg.sv
src/tcw_lin_unit.sv
src/tcw_cell_ram.sv
src/tcw_ctrl.sv
src/text_console_char_writer.sv
tb/sv/text_console_char_writer_test.sv
